/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file pts_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define PTS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("pts_checker: property failed");

// clocked property that is also checked during reset
`define PTS_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("pts_checker: reset property failed");

`endif

/* rtl/core/pts_pkg.sv */
// shared types and constants of the phase to sine/cosine block
// no dependencies
`default_nettype none

package pts_pkg;

    // default sizes
    localparam int OUT_BITS_DEF      = 16;
    localparam int PHASE_IN_BITS_DEF = 64;

    // configuration register
    localparam int          PHASE_BITS_W     = 6;
    localparam logic [5:0]  PHASE_BITS_RESET = 6'd32;
    localparam int          ANGLE_BITS       = 32;

    // q1.30 fixed point
    localparam int          FRAC_BITS   = 30;
    localparam logic [30:0] Q_ONE       = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // horner divisors, one pair per cell
    localparam int NUM_CELLS = 6;
    localparam int unsigned SIN_DIV [NUM_CELLS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [NUM_CELLS] = '{182, 132, 90, 56, 30, 12};

    // quadrant of the angle
    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quadrant;

    // context handed from cell to cell
    typedef struct packed {
        logic        valid;
        t_quadrant   quad;
        logic [30:0] theta;
        logic [31:0] t2;
        logic [30:0] a_sin;
        logic [30:0] a_cos;
    } t_cell_bus;

endpackage

`default_nettype wire

/* rtl/core/pts_phase_if.sv */
// phase word stream channel
// depends on pts_pkg
`default_nettype none

interface pts_phase_if #(
    parameter int PHASE_IN_BITS = pts_pkg::PHASE_IN_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic signed [PHASE_IN_BITS-1:0] phase_word;

    modport source (output valid, output phase_word, input ready);
    modport sink   (input valid, input phase_word, output ready);
endinterface

`default_nettype wire

/* rtl/core/pts_iq_if.sv */
// cosine/sine result stream channel
// depends on pts_pkg
`default_nettype none

interface pts_iq_if #(
    parameter int OUT_BITS = pts_pkg::OUT_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] in_phase;
    logic signed [OUT_BITS-1:0] quadrature;

    modport source (output valid, output in_phase, output quadrature, input ready);
    modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

`default_nettype wire

/* rtl/core/pts_cfg_if.sv */
// configuration write channel for the phase_bits register
// depends on pts_pkg
`default_nettype none

interface pts_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [pts_pkg::PHASE_BITS_W-1:0]  phase_bits;

    modport source (output valid, output phase_bits, input ready);
    modport sink   (input valid, input phase_bits, output ready);
endinterface

`default_nettype wire

/* rtl/core/pts_front.sv */
// angle front end: phase truncation, quadrant split, theta and theta squared
// depends on pts_pkg
`default_nettype none

module pts_front #(
    parameter int PHASE_IN_BITS = pts_pkg::PHASE_IN_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic signed [PHASE_IN_BITS-1:0]      i_phase_word,
    input  wire logic [pts_pkg::PHASE_BITS_W-1:0]     i_phase_bits,
    output pts_pkg::t_cell_bus                        o_bus
);

    localparam int P_MAX = (PHASE_IN_BITS < pts_pkg::ANGLE_BITS) ?
                           PHASE_IN_BITS : pts_pkg::ANGLE_BITS;

    logic [5:0]  p_eff;
    logic [4:0]  low_zero;
    logic [31:0] top32;
    logic [31:0] n_u;
    logic        r_a_valid;
    logic [31:0] r_u;

    logic [60:0] prod_theta;
    logic        r_b_valid;
    pts_pkg::t_quadrant r_b_quad;
    logic [30:0] r_b_theta;

    logic [61:0] prod_t2;
    pts_pkg::t_cell_bus r_c;
    pts_pkg::t_cell_bus n_c;

    // effective phase bits, clamped to the usable range
    always_comb begin
        if (i_phase_bits == '0) begin
            p_eff = 6'd1;
        end else if (i_phase_bits > 6'(P_MAX)) begin
            p_eff = 6'(P_MAX);
        end else begin
            p_eff = i_phase_bits;
        end
        low_zero = 5'(6'd32 - p_eff);
    end

    // top bits of the phase word, left aligned in the angle word
    generate
        if (PHASE_IN_BITS >= 32) begin : g_wide
            assign top32 = i_phase_word[PHASE_IN_BITS-1 -: 32];
        end else begin : g_narrow
            assign top32 = {i_phase_word, {(32 - PHASE_IN_BITS){1'b0}}};
        end
    endgenerate

    assign n_u = top32 & (32'hFFFF_FFFF << low_zero);

    // stage a: angle in turns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_u       <= n_u;
        end
    end

    // stage b: theta = r * pi/2 in q1.30
    assign prod_theta = 61'(r_u[29:0]) * 61'(pts_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
            r_b_quad  <= pts_pkg::t_quadrant'(r_u[31:30]);
            r_b_theta <= prod_theta[60:30];
        end
    end

    // stage c: theta squared, horner accumulators start at one
    assign prod_t2 = 62'(r_b_theta) * 62'(r_b_theta);

    always_comb begin
        n_c.valid = r_b_valid;
        n_c.quad  = r_b_quad;
        n_c.theta = r_b_theta;
        n_c.t2    = prod_t2[61:30];
        n_c.a_sin = pts_pkg::Q_ONE;
        n_c.a_cos = pts_pkg::Q_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_bus = r_c;

endmodule

`default_nettype wire

/* rtl/core/pts_cell.sv */
// one horner step for sine and cosine: a = one - ((t2 * a) >> 30) / k
// depends on pts_pkg
`default_nettype none

module pts_cell #(
    parameter int unsigned SIN_DIV = pts_pkg::SIN_DIV[0],
    parameter int unsigned COS_DIV = pts_pkg::COS_DIV[0]
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire pts_pkg::t_cell_bus  i_bus,
    output pts_pkg::t_cell_bus       o_bus
);

    // reciprocal constants, exact floor division for 32-bit dividends
    localparam int          SIN_SH     = 32 + $clog2(SIN_DIV);
    localparam logic [63:0] SIN_M_FULL = ((64'd1 << SIN_SH) / 64'(SIN_DIV)) + 64'd1;
    localparam logic [32:0] SIN_M      = SIN_M_FULL[32:0];
    localparam int          COS_SH     = 32 + $clog2(COS_DIV);
    localparam logic [63:0] COS_M_FULL = ((64'd1 << COS_SH) / 64'(COS_DIV)) + 64'd1;
    localparam logic [32:0] COS_M      = COS_M_FULL[32:0];

    typedef struct packed {
        logic               valid;
        pts_pkg::t_quadrant quad;
        logic [30:0]        theta;
        logic [31:0]        t2;
        logic [31:0]        x_sin;
        logic [31:0]        x_cos;
    } t_cell_mid;

    logic [62:0] prod_sin;
    logic [62:0] prod_cos;
    t_cell_mid   n_mid;
    t_cell_mid   r_mid;

    logic [64:0] rcp_sin;
    logic [64:0] rcp_cos;
    logic [30:0] quo_sin;
    logic [30:0] quo_cos;
    pts_pkg::t_cell_bus n_out;
    pts_pkg::t_cell_bus r_out;

    // first half: t2 * a
    assign prod_sin = 63'(i_bus.t2) * 63'(i_bus.a_sin);
    assign prod_cos = 63'(i_bus.t2) * 63'(i_bus.a_cos);

    always_comb begin
        n_mid.valid = i_bus.valid;
        n_mid.quad  = i_bus.quad;
        n_mid.theta = i_bus.theta;
        n_mid.t2    = i_bus.t2;
        n_mid.x_sin = prod_sin[61:30];
        n_mid.x_cos = prod_cos[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
        end else if (i_en) begin
            r_mid <= n_mid;
        end
    end

    // second half: divide by the constant through its reciprocal, subtract from one
    assign rcp_sin = 65'(r_mid.x_sin) * 65'(SIN_M);
    assign rcp_cos = 65'(r_mid.x_cos) * 65'(COS_M);
    assign quo_sin = 31'(rcp_sin >> SIN_SH);
    assign quo_cos = 31'(rcp_cos >> COS_SH);

    always_comb begin
        n_out.valid = r_mid.valid;
        n_out.quad  = r_mid.quad;
        n_out.theta = r_mid.theta;
        n_out.t2    = r_mid.t2;
        n_out.a_sin = pts_pkg::Q_ONE - quo_sin;
        n_out.a_cos = pts_pkg::Q_ONE - quo_cos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_bus = r_out;

endmodule

`default_nettype wire

/* rtl/core/pts_back.sv */
// back end: final sine/cosine terms, output scaling, quadrant mapping
// depends on pts_pkg
`default_nettype none

module pts_back #(
    parameter int OUT_BITS = pts_pkg::OUT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire pts_pkg::t_cell_bus          i_bus,
    output logic                             o_valid,
    output logic signed [OUT_BITS-1:0]       o_in_phase,
    output logic signed [OUT_BITS-1:0]       o_quadrature
);

    localparam int                PW    = 31 + OUT_BITS;
    localparam logic [OUT_BITS-2:0] SCALE = '1;
    localparam logic [PW-1:0]     ROUND = PW'(32'h2000_0000);

    logic [61:0] prod_s;
    logic [62:0] prod_c;

    logic               r_d_valid;
    pts_pkg::t_quadrant r_d_quad;
    logic [30:0]        r_d_sq;
    logic [31:0]        r_d_xc;

    logic [30:0]        half_c;
    logic               r_e_valid;
    pts_pkg::t_quadrant r_e_quad;
    logic [30:0]        r_e_sq;
    logic [30:0]        r_e_cq;

    logic [PW-1:0]       scaled_s;
    logic [PW-1:0]       scaled_c;
    logic                r_f_valid;
    pts_pkg::t_quadrant  r_f_quad;
    logic [OUT_BITS-1:0] r_f_mag_s;
    logic [OUT_BITS-1:0] r_f_mag_c;

    logic [OUT_BITS-1:0] neg_s;
    logic [OUT_BITS-1:0] neg_c;
    logic [OUT_BITS-1:0] n_i;
    logic [OUT_BITS-1:0] n_q;
    logic                r_g_valid;
    logic [OUT_BITS-1:0] r_g_i;
    logic [OUT_BITS-1:0] r_g_q;

    // stage d: sine = theta * a, cosine term = t2 * a
    assign prod_s = 62'(i_bus.theta) * 62'(i_bus.a_sin);
    assign prod_c = 63'(i_bus.t2) * 63'(i_bus.a_cos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= i_bus.valid;
            r_d_quad  <= i_bus.quad;
            r_d_sq    <= prod_s[60:30];
            r_d_xc    <= prod_c[61:30];
        end
    end

    // stage e: cosine = one - term / 2, floored at zero
    assign half_c = r_d_xc[31:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= r_d_valid;
            r_e_quad  <= r_d_quad;
            r_e_sq    <= r_d_sq;
            r_e_cq    <= (half_c >= pts_pkg::Q_ONE) ? '0 : pts_pkg::Q_ONE - half_c;
        end
    end

    // stage f: scale to full output range, round half up
    assign scaled_s = PW'(r_e_sq) * PW'(SCALE) + ROUND;
    assign scaled_c = PW'(r_e_cq) * PW'(SCALE) + ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_en) begin
            r_f_valid <= r_e_valid;
            r_f_quad  <= r_e_quad;
            r_f_mag_s <= scaled_s[pts_pkg::FRAC_BITS +: OUT_BITS];
            r_f_mag_c <= scaled_c[pts_pkg::FRAC_BITS +: OUT_BITS];
        end
    end

    // stage g: swap and negate by quadrant
    assign neg_s = OUT_BITS'(0) - r_f_mag_s;
    assign neg_c = OUT_BITS'(0) - r_f_mag_c;

    always_comb begin
        n_i = r_f_mag_c;
        n_q = r_f_mag_s;
        unique case (r_f_quad)
            pts_pkg::QUAD_I: begin
                n_i = r_f_mag_c;
                n_q = r_f_mag_s;
            end
            pts_pkg::QUAD_II: begin
                n_i = neg_s;
                n_q = r_f_mag_c;
            end
            pts_pkg::QUAD_III: begin
                n_i = neg_c;
                n_q = neg_s;
            end
            pts_pkg::QUAD_IV: begin
                n_i = r_f_mag_s;
                n_q = neg_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (i_en) begin
            r_g_valid <= r_f_valid;
            r_g_i     <= n_i;
            r_g_q     <= n_q;
        end
    end

    assign o_valid      = r_g_valid;
    assign o_in_phase   = r_g_i;
    assign o_quadrature = r_g_q;

endmodule

`default_nettype wire

/* rtl/core/phase_to_sine_cosine.sv */
// Phase to sine/cosine: a phase word in, cosine (in_phase) and sine (quadrature) out.
// Throughput: one beat per cycle; the pipeline is 19 register stages plus an output
// register with one skid entry, and a stall only holds the pipeline once the skid is full.
// Reset (synchronous, active low) empties the pipeline and sets phase_bits to 32.
// depends on pts_pkg, pts_phase_if, pts_iq_if, pts_cfg_if, pts_front, pts_cell, pts_back
`default_nettype none

module phase_to_sine_cosine #(
    parameter int OUT_BITS      = pts_pkg::OUT_BITS_DEF,
    parameter int PHASE_IN_BITS = pts_pkg::PHASE_IN_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pts_phase_if.sink  i_phase,
    pts_iq_if.source   o_iq,
    pts_cfg_if.sink    i_cfg
);

    logic [pts_pkg::PHASE_BITS_W-1:0] r_phase_bits;

    logic                pipe_en;
    pts_pkg::t_cell_bus  chain [pts_pkg::NUM_CELLS+1];

    logic                pipe_valid;
    logic [OUT_BITS-1:0] pipe_i;
    logic [OUT_BITS-1:0] pipe_q;

    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_i;
    logic [OUT_BITS-1:0] r_out_q;
    logic                r_skid_valid;
    logic [OUT_BITS-1:0] r_skid_i;
    logic [OUT_BITS-1:0] r_skid_q;

    // configuration register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_bits <= pts_pkg::PHASE_BITS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_phase_bits <= i_cfg.phase_bits;
        end
    end

    // pipeline moves whenever the skid entry is free
    assign pipe_en       = !r_skid_valid;
    assign i_phase.ready = pipe_en;

    pts_front #(
        .PHASE_IN_BITS (PHASE_IN_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_valid      (i_phase.valid),
        .i_phase_word (i_phase.phase_word),
        .i_phase_bits (r_phase_bits),
        .o_bus        (chain[0])
    );

    // horner cells, one divisor pair each
    generate
        for (genvar g = 0; g < pts_pkg::NUM_CELLS; g++) begin : g_cell
            pts_cell #(
                .SIN_DIV (pts_pkg::SIN_DIV[g]),
                .COS_DIV (pts_pkg::COS_DIV[g])
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (pipe_en),
                .i_bus   (chain[g]),
                .o_bus   (chain[g+1])
            );
        end
    endgenerate

    pts_back #(
        .OUT_BITS (OUT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_bus        (chain[pts_pkg::NUM_CELLS]),
        .o_valid      (pipe_valid),
        .o_in_phase   (pipe_i),
        .o_quadrature (pipe_q)
    );

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_iq.ready) begin
            r_out_valid  <= r_skid_valid || (pipe_valid && pipe_en);
            r_skid_valid <= 1'b0;
            if (r_skid_valid) begin
                r_out_i <= r_skid_i;
                r_out_q <= r_skid_q;
            end else begin
                r_out_i <= pipe_i;
                r_out_q <= pipe_q;
            end
        end else if (pipe_valid && pipe_en) begin
            r_skid_valid <= 1'b1;
            r_skid_i     <= pipe_i;
            r_skid_q     <= pipe_q;
        end
    end

    assign o_iq.valid      = r_out_valid;
    assign o_iq.in_phase   = r_out_i;
    assign o_iq.quadrature = r_out_q;

endmodule

`default_nettype wire

/* rtl/core/pts_checker.sv */
// port level checks of phase_to_sine_cosine, attached by bind
// depends on assert_macros.svh, pts_pkg and phase_to_sine_cosine
`default_nettype none
`include "assert_macros.svh"

module pts_checker #(
    parameter int OUT_BITS = pts_pkg::OUT_BITS_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [OUT_BITS-1:0] i_in_phase,
    input wire logic [OUT_BITS-1:0] i_quadrature
);

    // a stalled result beat stays up
    `PTS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // a stalled result beat keeps its payload
    `PTS_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_in_phase) && $stable(i_quadrature))

    // input backpressure only while a result is waiting
    `PTS_ASSERT(a_bp_cause, i_clk, i_rst_n, !i_in_ready |-> i_out_valid)

    // a taken result frees the input side on the next cycle
    `PTS_ASSERT(a_bp_release, i_clk, i_rst_n, i_out_ready |=> i_in_ready)

    // reset empties the output
    `PTS_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind phase_to_sine_cosine pts_checker #(
    .OUT_BITS (OUT_BITS)
) u_pts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_phase.ready),
    .i_out_valid  (o_iq.valid),
    .i_out_ready  (o_iq.ready),
    .i_in_phase   (o_iq.in_phase),
    .i_quadrature (o_iq.quadrature)
);

`default_nettype wire
